// ===== design/wsad_pkg.sv =====
`default_nettype none
package wsad_pkg;

    localparam int BYTE_W        = 8;
    localparam int FIELD_LANES   = 8;            // lanes that the 64-bit fields carry
    localparam int FIELD_W       = BYTE_W * FIELD_LANES;
    localparam int PROD_W        = 16;           // 255 * 256 fits
    localparam int BEAT_W        = PROD_W + 3;   // sum of up to eight products
    localparam int SUM_W         = 48;
    localparam int POS_W         = 20;
    localparam int BUDGET_W      = 16;
    localparam int CFG_W         = 20;
    localparam int CFG_IDX_W     = 1;
    localparam int LANES_DEFAULT = 8;
    localparam int WEIGHT_BIAS   = 129;

    localparam logic [SUM_W-1:0]    SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [BUDGET_W-1:0] BUDGET_RESET  = 16'd16;
    localparam logic [POS_W-1:0]    WINDOW_RESET  = 20'd64;

    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_BUDGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_WINDOW = 1'b1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef struct packed {
        logic             command;
        logic [POS_W-1:0] pos;
        logic             frame_last;
        logic             candidate_last;
    } beat_ctrl_t;

endpackage
`default_nettype wire

// ===== design/wsad_lane.sv =====
`default_nettype none
module wsad_lane (
    input  wire logic                          clk,
    input  wire logic                          load,
    input  wire logic [wsad_pkg::BYTE_W-1:0]   ref_byte,
    input  wire logic [wsad_pkg::BYTE_W-1:0]   cand_byte,
    output logic      [wsad_pkg::PROD_W-1:0]   product
);
    import wsad_pkg::*;

    logic signed [BYTE_W:0]   diff;
    logic        [BYTE_W-1:0] abs_diff;
    logic signed [BYTE_W+1:0] weight_wide;
    logic        [BYTE_W:0]   weight;
    logic        [2*BYTE_W:0] prod_wide;
    logic        [PROD_W-1:0] product_reg;

    always_comb
    begin
        diff        = $signed({ref_byte[BYTE_W-1], ref_byte})
                    - $signed({cand_byte[BYTE_W-1], cand_byte});
        abs_diff    = diff[BYTE_W] ? BYTE_W'(-diff) : diff[BYTE_W-1:0];
        // r + 129 lies in 1..256
        weight_wide = $signed({{2{ref_byte[BYTE_W-1]}}, ref_byte})
                    + $signed((BYTE_W+2)'(WEIGHT_BIAS));
        weight      = weight_wide[BYTE_W:0];
        prod_wide   = abs_diff * weight;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= prod_wide[PROD_W-1:0];
        end
    end

    assign product = product_reg;

endmodule
`default_nettype wire

// ===== design/wsad_merge.sv =====
`default_nettype none
module wsad_merge #(
    parameter int LANES = wsad_pkg::LANES_DEFAULT
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   advance,
    input  wire logic                                   beat_valid,
    input  wire wsad_pkg::beat_ctrl_t                   beat_ctrl,
    input  wire logic [LANES-1:0][wsad_pkg::PROD_W-1:0] products,
    output logic                                        sum_valid,
    output wsad_pkg::beat_ctrl_t                        sum_ctrl,
    output logic      [wsad_pkg::BEAT_W-1:0]            beat_sum
);
    import wsad_pkg::*;

    logic             sum_valid_reg;
    beat_ctrl_t       sum_ctrl_reg;
    logic [BEAT_W-1:0] beat_sum_reg;
    logic [BEAT_W-1:0] beat_sum_next;

    // lanes past the field width carry no bits and add nothing
    always_comb
    begin
        beat_sum_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (i < FIELD_LANES)
            begin
                beat_sum_next = beat_sum_next + BEAT_W'(products[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            sum_valid_reg <= beat_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_ctrl_reg <= beat_ctrl;
            beat_sum_reg <= beat_sum_next;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_ctrl  = sum_ctrl_reg;
    assign beat_sum  = beat_sum_reg;

endmodule
`default_nettype wire

// ===== design/wsad_judge.sv =====
`default_nettype none
module wsad_judge (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic                              cfg_write,
    input  wire logic [wsad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wsad_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              sum_valid,
    input  wire wsad_pkg::beat_ctrl_t              sum_ctrl,
    input  wire logic [wsad_pkg::BEAT_W-1:0]       beat_sum,
    input  wire logic                              result_stall,
    output logic                                   result_valid,
    output logic      [wsad_pkg::SUM_W-1:0]        cand_sum,
    output logic      [wsad_pkg::SUM_W-1:0]        best_sum,
    output logic      [wsad_pkg::POS_W-1:0]        best_pos,
    output logic                                   abandoned,
    output logic                                   search_done
);
    import wsad_pkg::*;

    logic [BUDGET_W-1:0] check_budget_reg;
    logic [POS_W-1:0]    check_window_reg;

    logic [SUM_W-1:0]    run_sum_reg, run_sum_next;
    logic [SUM_W-1:0]    best_total_reg, best_total_next;
    logic [POS_W-1:0]    best_position_reg, best_position_next;
    logic [BUDGET_W-1:0] checks_left_reg, checks_left_next;
    logic                cut_off_reg, cut_off_next;

    logic                result_valid_reg, result_valid_next;
    logic                emit;
    logic [SUM_W-1:0]    cand_sum_reg;
    logic [SUM_W-1:0]    best_sum_reg;
    logic [POS_W-1:0]    best_pos_reg;
    logic                abandoned_reg;
    logic                search_done_reg;

    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic                abandon;
    logic [POS_W-1:0]    pos_gap;
    logic                step;

    always_comb
    begin
        sum_wide = {1'b0, run_sum_reg} + (SUM_W+1)'(beat_sum);
        sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        abandon  = sum_ctrl.frame_last && (sum_sat > best_total_reg);
        pos_gap  = (sum_ctrl.pos >= best_position_reg) ? sum_ctrl.pos - best_position_reg
                                                       : best_position_reg - sum_ctrl.pos;
        step     = sum_valid && advance;

        run_sum_next       = run_sum_reg;
        best_total_next    = best_total_reg;
        best_position_next = best_position_reg;
        checks_left_next   = checks_left_reg;
        cut_off_next       = cut_off_reg;
        emit               = 1'b0;

        if (step)
        begin
            if (sum_ctrl.command == CMD_START)
            begin
                best_total_next    = SUM_MAX;
                best_position_next = '0;
                checks_left_next   = check_budget_reg;
                run_sum_next       = '0;
                cut_off_next       = 1'b0;
            end
            else if (checks_left_reg == '0)
            begin
                // search over, beat dropped
            end
            else if (cut_off_reg)
            begin
                if (sum_ctrl.candidate_last)
                begin
                    cut_off_next = 1'b0;
                    run_sum_next = '0;
                end
            end
            else
            begin
                run_sum_next = sum_sat;
                if (abandon || sum_ctrl.candidate_last)
                begin
                    emit = 1'b1;
                    if (sum_sat < best_total_reg)
                    begin
                        best_total_next    = sum_sat;
                        best_position_next = sum_ctrl.pos;
                        checks_left_next   = check_budget_reg;
                    end
                    else if (pos_gap <= check_window_reg)
                    begin
                        checks_left_next = checks_left_reg - 1'b1;
                    end
                    run_sum_next = '0;
                    cut_off_next = abandon && !sum_ctrl.candidate_last;
                end
            end
        end

        if (emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_budget_reg  <= BUDGET_RESET;
            check_window_reg  <= WINDOW_RESET;
            run_sum_reg       <= '0;
            best_total_reg    <= SUM_MAX;
            best_position_reg <= '0;
            checks_left_reg   <= '0;
            cut_off_reg       <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CHECK_BUDGET: check_budget_reg <= cfg_data[BUDGET_W-1:0];
                    CFG_CHECK_WINDOW: check_window_reg <= cfg_data[POS_W-1:0];
                    default:          ;
                endcase
            end
            run_sum_reg       <= run_sum_next;
            best_total_reg    <= best_total_next;
            best_position_reg <= best_position_next;
            checks_left_reg   <= checks_left_next;
            cut_off_reg       <= cut_off_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            cand_sum_reg    <= sum_sat;
            best_sum_reg    <= best_total_next;
            best_pos_reg    <= best_position_next;
            abandoned_reg   <= abandon;
            search_done_reg <= (checks_left_next == '0);
        end
    end

    assign result_valid = result_valid_reg;
    assign cand_sum     = cand_sum_reg;
    assign best_sum     = best_sum_reg;
    assign best_pos     = best_pos_reg;
    assign abandoned    = abandoned_reg;
    assign search_done  = search_done_reg;

    // the reported best never sits above the judged sum
    a_best_not_above: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (best_sum <= cand_sum))
        else $error("best_sum above cand_sum");

    // an abandoned candidate lost against the best
    a_abandon_worse: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && abandon) |=> (cand_sum > best_sum))
        else $error("abandoned candidate not worse than best");

    // a start command loads the full budget
    a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (step && sum_ctrl.command == CMD_START)
        |=> (checks_left_reg == $past(check_budget_reg) && !cut_off_reg))
        else $error("start command did not reload checks");

endmodule
`default_nettype wire

// ===== design/weighted_sad_best_offset_search.sv =====
// Pipeline: lane product registers, merge register, then the judge and its output register.
// Throughput: one item per cycle while no result is stalled; the per-candidate state update
// in the judge stage is a 48-bit add/compare, so beats can arrive back to back.
// A result waiting under result_stall holds the whole pipeline in place.
// Reset (rst_n, async low): pipeline empty, check_budget 16, check_window 64,
// best all ones, no checks left; data beats are dropped until a start command.
`default_nettype none
module weighted_sad_best_offset_search #(
    parameter int LANES = wsad_pkg::LANES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration writes
    input  wire logic                              cfg_write,
    input  wire logic [wsad_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [wsad_pkg::CFG_W-1:0]        cfg_data,
    // item channel
    input  wire logic                              item_valid,
    output logic                                   item_stall,
    input  wire logic                              command,
    input  wire logic [wsad_pkg::POS_W-1:0]        candidate_pos,
    input  wire logic [wsad_pkg::FIELD_W-1:0]      ref_bytes,
    input  wire logic [wsad_pkg::FIELD_W-1:0]      cand_bytes,
    input  wire logic                              frame_last,
    input  wire logic                              candidate_last,
    // result channel
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic      [wsad_pkg::SUM_W-1:0]        cand_sum,
    output logic      [wsad_pkg::SUM_W-1:0]        best_sum,
    output logic      [wsad_pkg::POS_W-1:0]        best_pos,
    output logic                                   abandoned,
    output logic                                   search_done
);
    import wsad_pkg::*;

    // Only the field's lanes carry bits; extra lanes are left unbuilt
    // and the merge stage treats them as zero.
    localparam int ACTIVE = (LANES < FIELD_LANES) ? LANES : FIELD_LANES;

    logic                          advance;
    logic                          s1_valid_reg;
    beat_ctrl_t                    s1_ctrl_reg;
    beat_ctrl_t                    item_ctrl;
    logic [LANES-1:0][PROD_W-1:0]  products;

    logic                          s2_valid;
    beat_ctrl_t                    s2_ctrl;
    logic [BEAT_W-1:0]             s2_beat_sum;

    // Whole pipeline moves unless a finished result is blocked downstream.
    assign advance    = !(result_valid && result_stall);
    assign item_stall = !advance;

    assign item_ctrl.command        = command;
    assign item_ctrl.pos            = candidate_pos;
    assign item_ctrl.frame_last     = frame_last;
    assign item_ctrl.candidate_last = candidate_last;

    // Stage 1: lane products, one weighted |r - c| per byte pair
    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            if (g < ACTIVE)
            begin : g_live
                wsad_lane u_lane (
                    .clk       (clk),
                    .load      (advance),
                    .ref_byte  (ref_bytes[g*BYTE_W +: BYTE_W]),
                    .cand_byte (cand_bytes[g*BYTE_W +: BYTE_W]),
                    .product   (products[g])
                );
            end
            else
            begin : g_dead
                assign products[g] = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_ctrl_reg <= item_ctrl;
        end
    end

    // Stage 2: fold the lane products into one beat sum
    wsad_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .beat_valid (s1_valid_reg),
        .beat_ctrl  (s1_ctrl_reg),
        .products   (products),
        .sum_valid  (s2_valid),
        .sum_ctrl   (s2_ctrl),
        .beat_sum   (s2_beat_sum)
    );

    // Stage 3: accumulate, abandon check, best tracking, output register
    wsad_judge u_judge (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sum_valid    (s2_valid),
        .sum_ctrl     (s2_ctrl),
        .beat_sum     (s2_beat_sum),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .cand_sum     (cand_sum),
        .best_sum     (best_sum),
        .best_pos     (best_pos),
        .abandoned    (abandoned),
        .search_done  (search_done)
    );

endmodule
`default_nettype wire
